FILE: src/oaht_pkg.sv
package oaht_pkg;

    localparam int TABLE_SIZE = 8;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int SLOT_W     = 3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MARK_FREE     = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_DELETED  = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FOUND    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_PROBE = 2'd1,
        FSM_DONE  = 2'd2
    } fsm_t;

    typedef struct packed {
        logic  en;
        logic  set_key;
        idx_t  idx;
        mark_t mark;
    } wr_cmd_t;

endpackage

FILE: src/oaht_store.sv
module oaht_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  oaht_pkg::idx_t     rd_idx,
    output oaht_pkg::key_t     rd_key,
    output oaht_pkg::mark_t    rd_mark,
    input  oaht_pkg::wr_cmd_t  wr,
    input  oaht_pkg::key_t     wr_key
);

    oaht_pkg::key_t  keys_reg  [oaht_pkg::TABLE_SIZE];
    oaht_pkg::mark_t marks_reg [oaht_pkg::TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (wr.en && wr.set_key) begin
            keys_reg[wr.idx] <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < oaht_pkg::TABLE_SIZE; i++) begin
                marks_reg[i] <= oaht_pkg::MARK_FREE;
            end
        end else if (wr.en) begin
            marks_reg[wr.idx] <= wr.mark;
        end
    end

    assign rd_key  = keys_reg[rd_idx];
    assign rd_mark = marks_reg[rd_idx];

endmodule

FILE: src/oaht_probe.sv
module oaht_probe (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [31:0]        s_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [2:0]         m_slot,
    output oaht_pkg::idx_t     rd_idx,
    input  oaht_pkg::key_t     rd_key,
    input  oaht_pkg::mark_t    rd_mark,
    output oaht_pkg::wr_cmd_t  wr,
    output oaht_pkg::key_t     wr_key
);

    localparam int IW = oaht_pkg::IDX_W;

    oaht_pkg::fsm_t    state_reg, state_next;
    oaht_pkg::action_t action_reg, action_next;
    oaht_pkg::key_t    key_reg, key_next;
    oaht_pkg::idx_t    pos_reg, pos_next;
    oaht_pkg::idx_t    k_reg, k_next;
    oaht_pkg::status_t status_reg, status_next;
    logic [oaht_pkg::SLOT_W-1:0] slot_reg, slot_next;

    oaht_pkg::idx_t home;
    oaht_pkg::idx_t step;
    oaht_pkg::idx_t adv_pos;
    logic [IW:0]    sum;
    logic           last;

    assign home = IW'(s_key % oaht_pkg::TABLE_SIZE);
    assign step = k_reg + IW'(1);
    assign sum  = (IW+1)'(pos_reg) + (IW+1)'(step);
    assign adv_pos = (sum >= (IW+1)'(oaht_pkg::TABLE_SIZE))
                   ? IW'(sum - (IW+1)'(oaht_pkg::TABLE_SIZE)) : IW'(sum);
    assign last = (k_reg == IW'(oaht_pkg::TABLE_SIZE - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oaht_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    always_comb begin
        state_next  = state_reg;
        action_next = action_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        wr.en       = 1'b0;
        wr.set_key  = 1'b0;
        wr.idx      = pos_reg;
        wr.mark     = oaht_pkg::MARK_OCCUPIED;

        unique case (state_reg)
            oaht_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    action_next = oaht_pkg::action_t'(s_action);
                    key_next    = s_key;
                    pos_next    = home;
                    k_next      = '0;
                    state_next  = oaht_pkg::FSM_PROBE;
                end
            end
            oaht_pkg::FSM_PROBE: begin
                unique case (action_reg)
                    oaht_pkg::ACT_INSERT: begin
                        if (rd_mark != oaht_pkg::MARK_OCCUPIED) begin
                            wr.en       = 1'b1;
                            wr.set_key  = 1'b1;
                            status_next = oaht_pkg::ST_INSERTED;
                            slot_next   = oaht_pkg::SLOT_W'(pos_reg);
                            state_next  = oaht_pkg::FSM_DONE;
                        end else if (last) begin
                            status_next = oaht_pkg::ST_FULL;
                            slot_next   = '0;
                            state_next  = oaht_pkg::FSM_DONE;
                        end else begin
                            pos_next = adv_pos;
                            k_next   = step;
                        end
                    end
                    oaht_pkg::ACT_REMOVE, oaht_pkg::ACT_LOOKUP: begin
                        if (rd_mark == oaht_pkg::MARK_FREE) begin
                            status_next = oaht_pkg::ST_ABSENT;
                            slot_next   = '0;
                            state_next  = oaht_pkg::FSM_DONE;
                        end else if (rd_key == key_reg) begin
                            state_next = oaht_pkg::FSM_DONE;
                            if (rd_mark != oaht_pkg::MARK_OCCUPIED) begin
                                status_next = oaht_pkg::ST_ABSENT;
                                slot_next   = '0;
                            end else if (action_reg == oaht_pkg::ACT_REMOVE) begin
                                wr.en       = 1'b1;
                                wr.mark     = oaht_pkg::MARK_DELETED;
                                status_next = oaht_pkg::ST_REMOVED;
                                slot_next   = oaht_pkg::SLOT_W'(pos_reg);
                            end else begin
                                status_next = oaht_pkg::ST_FOUND;
                                slot_next   = oaht_pkg::SLOT_W'(pos_reg);
                            end
                        end else if (last) begin
                            status_next = oaht_pkg::ST_ABSENT;
                            slot_next   = '0;
                            state_next  = oaht_pkg::FSM_DONE;
                        end else begin
                            pos_next = adv_pos;
                            k_next   = step;
                        end
                    end
                    default: begin
                        status_next = oaht_pkg::ST_ABSENT;
                        slot_next   = '0;
                        state_next  = oaht_pkg::FSM_DONE;
                    end
                endcase
            end
            oaht_pkg::FSM_DONE: begin
                if (m_ready) begin
                    state_next = oaht_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = oaht_pkg::FSM_IDLE;
            end
        endcase
    end

    assign rd_idx   = pos_reg;
    assign wr_key   = key_reg;
    assign s_ready  = (state_reg == oaht_pkg::FSM_IDLE);
    assign m_valid  = (state_reg == oaht_pkg::FSM_DONE);
    assign m_status = status_reg;
    assign m_slot   = slot_reg;

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides active together");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("no probe cycle after an accepted transaction");

    a_write_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == oaht_pkg::FSM_PROBE))
        else $error("table written outside probing");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == oaht_pkg::FSM_PROBE) |-> (pos_reg < oaht_pkg::TABLE_SIZE))
        else $error("probe position out of range");

    a_miss_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == oaht_pkg::ST_FULL || m_status == oaht_pkg::ST_ABSENT))
        |-> (m_slot == '0))
        else $error("nonzero slot on a miss");
`endif

endmodule

FILE: src/open_addressing_hash_table.sv
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// request  | s_valid, s_ready, s_action, s_key       | in
// result   | m_valid, m_ready, m_status, m_slot      | out
//
// A transaction is accepted in FSM_IDLE, then the single probe sequencer
// reads one slot at a time, from 1 up to TABLE_SIZE (8) probed slots.
// The result is then held until taken, and s_ready returns the cycle after.
// Reset clears all slot marks to free at once; no clearing pass is needed.
// A stalled result holds the block; no new transaction is taken meanwhile.
module open_addressing_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_slot
);

    oaht_pkg::idx_t    rd_idx;
    oaht_pkg::key_t    rd_key;
    oaht_pkg::mark_t   rd_mark;
    oaht_pkg::wr_cmd_t wr;
    oaht_pkg::key_t    wr_key;

    oaht_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (rd_idx),
        .rd_key  (rd_key),
        .rd_mark (rd_mark),
        .wr      (wr),
        .wr_key  (wr_key)
    );

    oaht_probe u_probe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_key    (s_key),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_slot   (m_slot),
        .rd_idx   (rd_idx),
        .rd_key   (rd_key),
        .rd_mark  (rd_mark),
        .wr       (wr),
        .wr_key   (wr_key)
    );

endmodule
